/* rtl/btw_pkg.sv */
// Shared types, constants and the record-length decode for the BTF type walker.
// Used by btw_in_stage, btw_walk and btf_type_record_walker; depends on nothing.
package btw_pkg;

  localparam int WORD_W   = 32;
  localparam int ID_W     = 31;
  localparam int LEFT_W   = 18;
  localparam int STATUS_W = 3;
  localparam int HP_W     = 2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNSUP    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PARTIAL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 3'd4;

  // Position within a record.
  localparam logic [HP_W-1:0] HP_NAME  = 2'd0;
  localparam logic [HP_W-1:0] HP_INFO  = 2'd1;
  localparam logic [HP_W-1:0] HP_SIZE  = 2'd2;
  localparam logic [HP_W-1:0] HP_TRAIL = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_SWAP     = 1'b0;
  localparam logic CFG_FIRST_ID = 1'b1;

  localparam logic [ID_W-1:0] MAX_TYPES = 31'h7fffffff;

  // Record kinds.
  localparam logic [4:0] KIND_INT        = 5'd1;
  localparam logic [4:0] KIND_ARRAY      = 5'd3;
  localparam logic [4:0] KIND_STRUCT     = 5'd4;
  localparam logic [4:0] KIND_UNION      = 5'd5;
  localparam logic [4:0] KIND_ENUM       = 5'd6;
  localparam logic [4:0] KIND_FUNC_PROTO = 5'd13;
  localparam logic [4:0] KIND_VAR        = 5'd14;
  localparam logic [4:0] KIND_DATASEC    = 5'd15;
  localparam logic [4:0] KIND_DECL_TAG   = 5'd17;
  localparam logic [4:0] KIND_ENUM64     = 5'd19;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } btw_item_t;

  typedef struct packed {
    logic              swap_bytes;
    logic [ID_W-1:0]   first_type_id;
  } btw_cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0]   out_word;
    logic                entry_valid;
    logic [ID_W-1:0]     type_id;
    logic [WORD_W-1:0]   entry_offset;
    logic [STATUS_W-1:0] status;
    logic                section_end;
  } btw_result_t;

  function automatic logic kind_supported(input logic [4:0] kind);
    kind_supported = kind inside {[KIND_INT:KIND_ENUM64]};
  endfunction

  // Number of words that follow the three-word header.
  function automatic logic [LEFT_W-1:0] rec_words(input logic [4:0] kind,
                                                  input logic [15:0] vlen);
    logic [LEFT_W-1:0] v;
    v = {{(LEFT_W-16){1'b0}}, vlen};
    case (kind)
      KIND_INT, KIND_VAR, KIND_DECL_TAG:
        rec_words = LEFT_W'(1);
      KIND_ARRAY:
        rec_words = LEFT_W'(3);
      KIND_ENUM, KIND_FUNC_PROTO:
        rec_words = v << 1;
      KIND_STRUCT, KIND_UNION, KIND_DATASEC, KIND_ENUM64:
        rec_words = (v << 1) + v;
      default:
        rec_words = '0;
    endcase
  endfunction

endpackage

/* rtl/btw_in_stage.sv */
// Input register of the walker: holds one accepted word until the walker takes it.
// Depends on btw_pkg for the item type.
module btw_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  btw_pkg::btw_item_t in_item,
  output logic               stage_valid,
  output btw_pkg::btw_item_t stage_item,
  input  logic               take
);
  import btw_pkg::*;

  // A new word may enter while the held one moves on in the same cycle.
  assign in_ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
  end

endmodule

/* rtl/btw_walk.sv */
// Record walker: holds the section state and works out one result per word.
// Depends on btw_pkg for types, status codes and the record-length decode.
module btw_walk (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  btw_pkg::btw_item_t   item,
  input  btw_pkg::btw_cfg_t    cfg,
  output btw_pkg::btw_result_t result
);
  import btw_pkg::*;

  logic [HP_W-1:0]     header_position, header_position_next;
  logic [LEFT_W-1:0]   words_left, words_left_next;
  logic [WORD_W-1:0]   record_start_offset, record_start_offset_next;
  logic [WORD_W-1:0]   running_offset, running_offset_next;
  logic [ID_W-1:0]     types_seen, types_seen_next;
  logic                error_hold, error_hold_next;
  logic                kind_bad, kind_bad_next;
  logic [STATUS_W-1:0] held_code, held_code_next;

  logic [WORD_W-1:0]   w;
  logic [LEFT_W-1:0]   left_dec;
  logic [STATUS_W-1:0] code;
  logic                done;

  assign w = cfg.swap_bytes ? {item.word[7:0], item.word[15:8],
                               item.word[23:16], item.word[31:24]} : item.word;
  assign left_dec = words_left - LEFT_W'(1);

  always_comb begin
    header_position_next     = header_position;
    words_left_next          = words_left;
    record_start_offset_next = record_start_offset;
    running_offset_next      = running_offset;
    types_seen_next          = types_seen;
    error_hold_next          = error_hold;
    kind_bad_next            = kind_bad;
    held_code_next           = held_code;
    code                     = ST_OK;
    done                     = 1'b0;

    result              = '0;
    result.out_word     = w;

    if (fire && error_hold) begin
      // Words after an error are passed through untouched until the section closes.
      if (item.last) begin
        result.status      = held_code;
        result.section_end = 1'b1;
      end
    end else if (fire) begin
      running_offset_next = running_offset + WORD_W'(4);
      case (header_position)
        HP_NAME: begin
          record_start_offset_next = running_offset;
          header_position_next     = HP_INFO;
          if (item.last) code = ST_PARTIAL;
        end
        HP_INFO: begin
          kind_bad_next        = !kind_supported(w[28:24]);
          words_left_next      = rec_words(w[28:24], w[15:0]);
          header_position_next = HP_SIZE;
          if (item.last) code = ST_PARTIAL;
        end
        HP_SIZE: begin
          if (kind_bad) begin
            code = ST_UNSUP;
          end else if (words_left == '0) begin
            done = 1'b1;
          end else begin
            header_position_next = HP_TRAIL;
            if (item.last) code = ST_TRUNC;
          end
        end
        HP_TRAIL: begin
          words_left_next = left_dec;
          if (left_dec == '0) begin
            done = 1'b1;
          end else if (item.last) begin
            code = ST_TRUNC;
          end
        end
        default: begin
          header_position_next = HP_NAME;
        end
      endcase

      if (done) begin
        if (types_seen == MAX_TYPES) begin
          code = ST_TOO_MANY;
        end else begin
          result.entry_valid  = 1'b1;
          result.type_id      = cfg.first_type_id + types_seen;
          result.entry_offset = record_start_offset;
          types_seen_next     = types_seen + ID_W'(1);
        end
        header_position_next = HP_NAME;
        words_left_next      = '0;
        kind_bad_next        = 1'b0;
      end

      if (code != ST_OK) begin
        error_hold_next = 1'b1;
        held_code_next  = code;
        result.status   = code;
      end
      result.section_end = item.last;
    end

    // The closing word returns the section state to its starting point.
    if (fire && item.last) begin
      header_position_next     = HP_NAME;
      words_left_next          = '0;
      record_start_offset_next = '0;
      running_offset_next      = '0;
      types_seen_next          = '0;
      error_hold_next          = 1'b0;
      kind_bad_next            = 1'b0;
      held_code_next           = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position     <= HP_NAME;
      words_left          <= '0;
      record_start_offset <= '0;
      running_offset      <= '0;
      types_seen          <= '0;
      error_hold          <= 1'b0;
      kind_bad            <= 1'b0;
      held_code           <= ST_OK;
    end else begin
      header_position     <= header_position_next;
      words_left          <= words_left_next;
      record_start_offset <= record_start_offset_next;
      running_offset      <= running_offset_next;
      types_seen          <= types_seen_next;
      error_hold          <= error_hold_next;
      kind_bad            <= kind_bad_next;
      held_code           <= held_code_next;
    end
  end

  a_entry_clean: assert property (@(posedge clk) disable iff (rst)
    result.entry_valid |-> (result.status == ST_OK) && !error_hold)
    else $error("entry reported alongside an error");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.last |=> (header_position == HP_NAME) && (running_offset == '0)
                          && (types_seen == '0) && !error_hold)
    else $error("section state not cleared after closing word");

  a_trail_nonzero: assert property (@(posedge clk) disable iff (rst)
    (header_position == HP_TRAIL) |-> (words_left != '0))
    else $error("in trailing words with nothing left to count");

  a_hold_code: assert property (@(posedge clk) disable iff (rst)
    error_hold |-> (held_code != ST_OK))
    else $error("error held without a code");

endmodule

/* rtl/btf_type_record_walker.sv */
// Top level of the BTF type section walker: configuration registers, input stage,
// walker and result register. Depends on btw_pkg, btw_in_stage and btw_walk.
//
// The block takes the type section one 32-bit word per transfer and returns one
// result per word, in order, with the word in native byte order, the id and byte
// offset of each record as its last word goes past, and the section status on the
// word marked last. It sustains one word per clock cycle while results are taken
// as they come. An accepted word is held in the input register and then passes
// through the walker's combinational result logic (record-length decode, count and
// offset update) into the result register, where it is presented. While a finished
// result waits to be taken, one more word is accepted into the input register and
// the input then stalls until the result is taken. There is no clearing pass after
// reset. Configuration writes are always taken at once; they should be made only
// while no word is in flight.
module btf_type_record_walker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] word,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic        entry_valid,
  output logic [30:0] type_id,
  output logic [31:0] entry_offset,
  output logic [2:0]  status,
  output logic        section_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import btw_pkg::*;

  btw_cfg_t    cfg;
  btw_item_t   in_item;
  btw_item_t   stage_item;
  btw_result_t walk_result;
  btw_result_t out_result;
  logic        stage_valid;
  logic        take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swap_bytes    <= 1'b0;
      cfg.first_type_id <= ID_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SWAP:     cfg.swap_bytes    <= cfg_data[0];
        CFG_FIRST_ID: cfg.first_type_id <= cfg_data[ID_W-1:0];
        default:      cfg.swap_bytes    <= cfg.swap_bytes;
      endcase
    end
  end

  assign in_item.word = word;
  assign in_item.last = last;

  btw_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .take        (take)
  );

  // The held word moves on whenever the result register is empty or being emptied.
  assign take = stage_valid && (!out_valid || out_ready);

  btw_walk u_walk (
    .clk    (clk),
    .rst    (rst),
    .fire   (take),
    .item   (stage_item),
    .cfg    (cfg),
    .result (walk_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_result <= walk_result;
    end
  end

  assign out_word     = out_result.out_word;
  assign entry_valid  = out_result.entry_valid;
  assign type_id      = out_result.type_id;
  assign entry_offset = out_result.entry_offset;
  assign status       = out_result.status;
  assign section_end  = out_result.section_end;

endmodule

/* bench/btw_walk_checker.sv */
`timescale 1ns / 100ps
// Watches the word, result and register channels of btf_type_record_walker,
// predicts each result from its own copy of the walker state and compares them.
// Depends on btw_pkg for the result layout, status codes and record kinds.
module btw_walk_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] word,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_word,
  input  logic        entry_valid,
  input  logic [30:0] type_id,
  input  logic [31:0] entry_offset,
  input  logic [2:0]  status,
  input  logic        section_end,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          words_in,
  output int          records,
  output int          sections,
  output int          bad_sections
);
  import btw_pkg::*;

  localparam int PRINT_LIMIT = 40;

  // Register copies.
  logic                swap_cfg;
  logic [ID_W-1:0]     base_id;

  // Walker state.
  logic [HP_W-1:0]     pos;
  logic [LEFT_W-1:0]   trail_left;
  logic [WORD_W-1:0]   rec_off;
  logic [WORD_W-1:0]   byte_off;
  logic [ID_W-1:0]     rec_count;
  logic                in_error;
  logic                bad_kind;
  logic [STATUS_W-1:0] held_status;

  btw_result_t due_results[$];

  initial begin
    errors = 0;
    pending = 0;
    words_in = 0;
    records = 0;
    sections = 0;
    bad_sections = 0;
  end

  task automatic note_failure(input string msg);
    if (errors < PRINT_LIMIT)
      $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [LEFT_W-1:0] trailing_words(input logic [4:0] kind,
                                                       input logic [15:0] vlen);
    logic [LEFT_W-1:0] n;
    n = LEFT_W'(vlen);
    case (kind)
      KIND_INT, KIND_VAR, KIND_DECL_TAG:  trailing_words = LEFT_W'(1);
      KIND_ARRAY:                         trailing_words = LEFT_W'(3);
      KIND_ENUM, KIND_FUNC_PROTO:         trailing_words = LEFT_W'(n * 2);
      KIND_STRUCT, KIND_UNION, KIND_DATASEC, KIND_ENUM64:
        trailing_words = LEFT_W'(n * 3);
      default:                            trailing_words = '0;
    endcase
  endfunction

  task automatic clear_section();
    pos = HP_NAME;
    trail_left = '0;
    rec_off = '0;
    byte_off = '0;
    rec_count = '0;
    in_error = 1'b0;
    bad_kind = 1'b0;
    held_status = ST_OK;
  endtask

  // Advances the walker by one stored word and gives the result it produces.
  task automatic walk_word(input logic [31:0] raw, input logic lst,
                           output btw_result_t r);
    logic [31:0]         w;
    logic [31:0]         off;
    logic [STATUS_W-1:0] code;
    logic                done;
    w = swap_cfg ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
    r = '0;
    r.out_word = w;
    code = ST_OK;
    done = 1'b0;
    if (in_error) begin
      // Everything up to the closing word is skipped once an error is held.
      if (lst) begin
        r.status = held_status;
        r.section_end = 1'b1;
        clear_section();
      end
    end else begin
      off = byte_off;
      byte_off = byte_off + 32'd4;
      case (pos)
        HP_NAME: begin
          rec_off = off;
          pos = HP_INFO;
          if (lst) code = ST_PARTIAL;
        end
        HP_INFO: begin
          bad_kind = !(w[28:24] >= KIND_INT && w[28:24] <= KIND_ENUM64);
          trail_left = trailing_words(w[28:24], w[15:0]);
          pos = HP_SIZE;
          if (lst) code = ST_PARTIAL;
        end
        HP_SIZE: begin
          if (bad_kind)
            code = ST_UNSUP;
          else if (trail_left == '0)
            done = 1'b1;
          else begin
            pos = HP_TRAIL;
            if (lst) code = ST_TRUNC;
          end
        end
        default: begin
          trail_left = trail_left - 1'b1;
          if (trail_left == '0)
            done = 1'b1;
          else if (lst)
            code = ST_TRUNC;
        end
      endcase
      if (done) begin
        if (rec_count >= MAX_TYPES)
          code = ST_TOO_MANY;
        else begin
          r.entry_valid = 1'b1;
          r.type_id = base_id + rec_count;
          r.entry_offset = rec_off;
          rec_count = rec_count + 1'b1;
        end
        pos = HP_NAME;
        trail_left = '0;
        bad_kind = 1'b0;
      end
      if (code != ST_OK) begin
        in_error = 1'b1;
        held_status = code;
        r.status = code;
      end
      if (lst) begin
        r.section_end = 1'b1;
        clear_section();
      end
    end
  endtask

  task automatic check_result(input btw_result_t got);
    btw_result_t want;
    if (due_results.size() == 0) begin
      note_failure($sformatf("result with word %h and no word outstanding", got.out_word));
    end else begin
      want = due_results.pop_front();
      if (got.out_word !== want.out_word)
        note_failure($sformatf("out_word %h, predicted %h", got.out_word, want.out_word));
      if (got.entry_valid !== want.entry_valid)
        note_failure($sformatf("entry_valid %b, predicted %b",
                               got.entry_valid, want.entry_valid));
      if (got.type_id !== want.type_id)
        note_failure($sformatf("type_id %h, predicted %h", got.type_id, want.type_id));
      if (got.entry_offset !== want.entry_offset)
        note_failure($sformatf("entry_offset %h, predicted %h",
                               got.entry_offset, want.entry_offset));
      if (got.status !== want.status)
        note_failure($sformatf("status %0d, predicted %0d", got.status, want.status));
      if (got.section_end !== want.section_end)
        note_failure($sformatf("section_end %b, predicted %b",
                               got.section_end, want.section_end));
      records += want.entry_valid;
      if (want.section_end) begin
        sections++;
        if (want.status != ST_OK) bad_sections++;
      end
    end
  endtask

  always @(posedge clk) begin
    btw_result_t want;
    btw_result_t got;
    if (rst) begin
      swap_cfg = 1'b0;
      base_id = ID_W'(1);
      clear_section();
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SWAP)
          swap_cfg = cfg_data[0];
        else if (cfg_index == CFG_FIRST_ID)
          base_id = cfg_data[ID_W-1:0];
      end
      if (in_valid && in_ready) begin
        walk_word(word, last, want);
        due_results.push_back(want);
        words_in++;
      end
      if (out_valid && out_ready) begin
        got.out_word = out_word;
        got.entry_valid = entry_valid;
        got.type_id = type_id;
        got.entry_offset = entry_offset;
        got.status = status;
        got.section_end = section_end;
        check_result(got);
      end
    end
    pending <= due_results.size();
  end

endmodule

/* bench/btf_type_record_walker_tb.sv */
`timescale 1ns / 100ps
// Stimulus and verdict for btf_type_record_walker: builds type sections, drives
// the word and register channels, and relies on btw_walk_checker for the checks.
// Depends on btw_pkg, btf_type_record_walker and btw_walk_checker.
module btf_type_record_walker_tb;
  import btw_pkg::*;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          N_PHASES       = 5;
  localparam int          PHASE_WORDS    = 245;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          HOLD_AFTER     = 500;
  localparam logic [4:0]  KIND_VOID      = 5'd0;
  localparam logic [4:0]  KIND_PTR       = 5'd2;
  localparam logic [4:0]  KIND_BAD_LO    = 5'd20;
  localparam logic [4:0]  KIND_BAD_HI    = 5'd31;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] word;
  logic        last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_word;
  logic        entry_valid;
  logic [30:0] type_id;
  logic [31:0] entry_offset;
  logic [2:0]  status;
  logic        section_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  int errors, pending, words_in, records, sections, bad_sections;
  int words_sent    = 0;
  int results_taken = 0;
  int max_gap       = 8;
  int idle_cycles   = 0;
  logic cur_swap    = 1'b0;

  // Native-order words of the section being built, with the last flag on top.
  logic [32:0] section_words[$];

  btf_type_record_walker dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .word(word), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .entry_valid(entry_valid), .type_id(type_id), .entry_offset(entry_offset),
    .status(status), .section_end(section_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  btw_walk_checker walk_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .word(word), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .entry_valid(entry_valid), .type_id(type_id), .entry_offset(entry_offset),
    .status(status), .section_end(section_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .words_in(words_in), .records(records),
    .sections(sections), .bad_sections(bad_sections)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A transfer on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("No transfer for %0d cycles, giving up.", idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stalls, and one long hold-off while words keep coming,
  // so that the block fills up and has to stall its input.
  initial begin
    int stall;
    int max_stall;
    bit held_off;
    max_stall = 8;
    held_off = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (results_taken % 40 == 0)
        max_stall = ($urandom_range(0, 3) == 0) ? 0 : 8;
      stall = $urandom_range(0, max_stall);
      if (!held_off && results_taken >= HOLD_AFTER && in_valid) begin
        stall = HOLD_CYCLES;
        held_off = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  function automatic logic [31:0] byte_swap(input logic [31:0] v);
    byte_swap = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // Words that follow the header, for building well-formed records.
  function automatic int trail_count(input logic [4:0] kind, input logic [15:0] vlen);
    case (kind)
      KIND_INT, KIND_VAR, KIND_DECL_TAG:                  trail_count = 1;
      KIND_ARRAY:                                         trail_count = 3;
      KIND_ENUM, KIND_FUNC_PROTO:                         trail_count = 2 * vlen;
      KIND_STRUCT, KIND_UNION, KIND_DATASEC, KIND_ENUM64: trail_count = 3 * vlen;
      default:                                            trail_count = 0;
    endcase
  endfunction

  task automatic send_word(input logic lst, input logic [31:0] native);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    word <= cur_swap ? byte_swap(native) : native;
    last <= lst;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_queue();
    logic [32:0] item;
    while (section_words.size() > 0) begin
      item = section_words.pop_front();
      send_word(item[32], item[31:0]);
    end
  endtask

  task automatic put(input logic [31:0] w);
    section_words.push_back({1'b0, w});
  endtask

  task automatic end_section();
    logic [32:0] item;
    item = section_words.pop_back();
    item[32] = 1'b1;
    section_words.push_back(item);
  endtask

  // Header words; with randomise clear every free bit takes the value of fill.
  task automatic put_header(input logic [4:0] kind, input logic [15:0] vlen,
                            input logic [31:0] fill, input bit randomise);
    logic [31:0] spare;
    spare = randomise ? $urandom() : fill;
    put(randomise ? $urandom() : fill);
    put({spare[31:29], kind, spare[23:16], vlen});
    put(randomise ? $urandom() : fill);
  endtask

  task automatic add_record(input logic [4:0] kind, input logic [15:0] vlen,
                            input logic [31:0] fill, input bit randomise);
    put_header(kind, vlen, fill, randomise);
    repeat (trail_count(kind, vlen)) put(randomise ? $urandom() : fill);
  endtask

  task automatic add_random_record();
    logic [4:0]  kind;
    logic [15:0] vlen;
    kind = 5'($urandom_range(KIND_INT, KIND_ENUM64));
    if (trail_count(kind, 16'd0) == trail_count(kind, 16'd1))
      vlen = 16'($urandom());
    else if ($urandom_range(0, 39) == 0)
      vlen = 16'($urandom_range(5, 100));
    else
      vlen = 16'($urandom_range(0, 4));
    add_record(kind, vlen, 32'h0, 1'b1);
  endtask

  // Mostly well-formed sections; some cut short, some with a bad kind, some pure
  // noise, and some left open so that the next section carries on the record.
  task automatic random_section();
    int mode;
    int nrec;
    int cut;
    int bad_at;
    logic [4:0] bad;
    mode = $urandom_range(0, 9);
    nrec = $urandom_range(1, 5);
    bad_at = (mode == 7) ? $urandom_range(0, nrec - 1) : -1;
    max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
    if (mode == 8) begin
      repeat ($urandom_range(1, 12)) put($urandom());
    end else begin
      for (int i = 0; i < nrec; i++) begin
        if (i == bad_at) begin
          if ($urandom_range(0, 3) == 0)
            bad = KIND_VOID;
          else
            bad = 5'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
          add_record(bad, 16'($urandom()), 32'h0, 1'b1);
        end else begin
          add_random_record();
        end
      end
    end
    if (mode == 6) begin
      cut = $urandom_range(1, section_words.size());
      while (section_words.size() > cut) void'(section_words.pop_back());
    end
    if (mode != 9) end_section();
    send_queue();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic sw, input logic [30:0] id);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SWAP;
    cfg_data <= {31'($urandom()), sw};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_FIRST_ID;
    cfg_data <= {1'($urandom()), id};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_swap = sw;
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    word <= '0;
    last <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SWAP;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sections under the reset settings. A record of every length class
    // but the three-word array class, with all-zero and all-one fields.
    add_record(KIND_INT, 16'h0000, 32'h0000_0000, 1'b0);
    add_record(KIND_STRUCT, 16'h0000, 32'hffff_ffff, 1'b0);
    add_record(KIND_PTR, 16'hffff, 32'h0000_0000, 1'b0);
    add_record(KIND_ENUM, 16'h0001, 32'hffff_ffff, 1'b0);
    end_section();
    // Unsupported kind, followed by a word that must be skipped.
    put_header(KIND_VOID, 16'h1234, 32'h0, 1'b1);
    put($urandom());
    end_section();
    // Section that stops on the name word.
    put($urandom());
    end_section();
    // Section that stops on the info word of a bad kind with the longest vlen.
    put_header(KIND_BAD_HI, 16'hffff, 32'h0, 1'b1);
    void'(section_words.pop_back());
    end_section();
    // Longest member list, cut off after two of its trailing words.
    put_header(KIND_STRUCT, 16'hffff, 32'hffff_ffff, 1'b0);
    put(32'h0);
    put(32'hffff_ffff);
    end_section();
    send_queue();

    // Random phases, each under its own settings. The type-count limit needs
    // 2^31 records in one section and cannot be reached here.
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0:       set_config(1'b1, 31'h7fff_ffff);
        1:       set_config(1'b0, 31'h0000_0000);
        2:       set_config(1'b1, 31'($urandom()));
        3:       set_config(1'b0, 31'h7fff_fffe);
        default: set_config(1'b1, 31'h0000_0001);
      endcase
      while (words_sent < 27 + (p + 1) * PHASE_WORDS) random_section();
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Walked %0d words over %0d closed sections, %0d records completed.",
             words_in, sections, records);
    $display("%0d sections closed with an error status; %0d mismatches found.",
             bad_sections, errors);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
rtl/btw_pkg.sv
rtl/btw_in_stage.sv
rtl/btw_walk.sv
rtl/btf_type_record_walker.sv
bench/btw_walk_checker.sv
bench/btf_type_record_walker_tb.sv
